[rtl/ast_pkg.sv]
`timescale 1ns / 1ps
package ast_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int CORDIC_ITERS_DEF = 16;
    localparam int SEG_W = 6;
    localparam int COORD_W = 24;
    localparam int RAD_W = 23;
    localparam int ANG_W = 16;
    localparam int COLOR_W = 32;
    localparam int TRIG_W = 34;
    localparam logic signed [TRIG_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sd8388607;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sd8388608;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [RAD_W-1:0]          r1;
        logic [RAD_W-1:0]          r2;
        logic [ANG_W-1:0]          start;
        logic [ANG_W-1:0]          q0;
        logic [SEG_W-1:0]          r0;
        logic [SEG_W-1:0]          n;
        logic [COLOR_W-1:0]        color;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vert;

    // arctangent of 2^-i as a 32 bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ast_ifs.sv]
`timescale 1ns / 1ps
interface ast_sector_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] dir_x;
    logic signed [23:0] dir_y;
    logic [22:0]        inner_radius;
    logic [22:0]        outer_radius;
    logic [15:0]        sweep_angle;
    logic [5:0]         segment_count;
    logic [31:0]        fill_color;
    modport source(output valid, origin_x, origin_y, dir_x, dir_y, inner_radius,
                   outer_radius, sweep_angle, segment_count, fill_color, input ready);
    modport sink(input valid, origin_x, origin_y, dir_x, dir_y, inner_radius,
                 outer_radius, sweep_angle, segment_count, fill_color, output ready);
endinterface

interface ast_tri_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by_coord;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [31:0]        tri_color;
    logic               last_triangle;
    modport source(output valid, ax, ay, bx, by_coord, cx, cy, tri_color, last_triangle,
                   input ready);
    modport sink(input valid, ax, ay, bx, by_coord, cx, cy, tri_color, last_triangle,
                 output ready);
endinterface

[rtl/ast_front.sv]
`timescale 1ns / 1ps
module ast_front import ast_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ast_sector_if.sink i_sector,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);
    localparam int RUN_LEN = (CORDIC_ITERS > ANG_W) ? CORDIC_ITERS : ANG_W;
    localparam int KW = $clog2(RUN_LEN);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RUN  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate            r_state;
    t_cmd               r_cmd;
    logic signed [47:0] r_x, r_y;
    logic [31:0]        r_z;
    logic               r_zero;
    logic [SEG_W-1:0]   r_rem;
    logic [ANG_W-1:0]   r_quo;
    logic [KW-1:0]      r_k;

    logic [SEG_W-1:0]   n_cnt;
    logic signed [47:0] n_x0, n_y0;
    logic signed [47:0] n_x, n_y, sx, sy;
    logic [31:0]        n_z, atn, rnd;
    logic [SEG_W:0]     div_try;
    logic               div_ge;

    assign i_sector.ready = (r_state == F_IDLE);
    assign n_cnt = (i_sector.segment_count > SEG_W'(MAX_SEGMENTS))
                   ? SEG_W'(MAX_SEGMENTS) : i_sector.segment_count;
    // vectoring runs on (dir_y, dir_x), so the angle is taken from +y
    assign n_x0 = {{4{i_sector.dir_y[23]}}, i_sector.dir_y, 20'b0};
    assign n_y0 = {{4{i_sector.dir_x[23]}}, i_sector.dir_x, 20'b0};

    always_comb begin
        atn = atan_entry(5'(r_k));
        sx = r_x >>> r_k;
        sy = r_y >>> r_k;
        if (r_y > 48'sd0) begin
            n_x = r_x + sy;
            n_y = r_y - sx;
            n_z = r_z + atn;
        end else begin
            n_x = r_x - sy;
            n_y = r_y + sx;
            n_z = r_z - atn;
        end
        div_try = {r_rem, r_quo[ANG_W-1]};
        div_ge = (div_try >= {1'b0, r_cmd.n});
        rnd = r_z + 32'h0000_8000;
    end

    always_comb begin
        o_cmd = r_cmd;
        o_cmd.start = r_zero ? '0 : rnd[31:16];
        o_cmd.q0 = r_quo;
        o_cmd.r0 = r_rem;
    end
    assign o_push = (r_state == F_PUSH) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_sector.valid && n_cnt != '0) begin
                        r_state <= F_RUN;
                    end
                end
                F_RUN: begin
                    if (r_k == KW'(RUN_LEN - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_cmd.ox    <= i_sector.origin_x;
            r_cmd.oy    <= i_sector.origin_y;
            r_cmd.r1    <= i_sector.inner_radius;
            r_cmd.r2    <= i_sector.outer_radius;
            r_cmd.n     <= n_cnt;
            r_cmd.color <= i_sector.fill_color;
            r_cmd.start <= '0;
            r_cmd.q0    <= '0;
            r_cmd.r0    <= '0;
            r_zero      <= (i_sector.dir_x == '0) && (i_sector.dir_y == '0);
            r_rem       <= '0;
            r_quo       <= i_sector.sweep_angle;
            r_k         <= '0;
            if (n_x0 < 48'sd0) begin
                r_x <= -n_x0;
                r_y <= -n_y0;
                r_z <= 32'h8000_0000;
            end else begin
                r_x <= n_x0;
                r_y <= n_y0;
                r_z <= '0;
            end
        end else if (r_state == F_RUN) begin
            r_k <= r_k + KW'(1);
            if (32'(r_k) < CORDIC_ITERS) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
            if (32'(r_k) < ANG_W) begin
                r_rem <= div_ge ? SEG_W'(div_try - {1'b0, r_cmd.n}) : div_try[SEG_W-1:0];
                r_quo <= {r_quo[ANG_W-2:0], div_ge};
            end
        end
    end
endmodule

[rtl/ast_queue.sv]
`timescale 1ns / 1ps
module ast_queue import ast_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

[rtl/ast_back.sv]
`timescale 1ns / 1ps
module ast_back import ast_pkg::*; #(
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_cmd     i_cmd,
    output logic     o_pop,
    ast_tri_if.source o_tri
);
    localparam int KW = $clog2(CORDIC_ITERS);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_ANG   = 6'b000010,
        B_CORD  = 6'b000100,
        B_MUL   = 6'b001000,
        B_EMIT0 = 6'b010000,
        B_EMIT1 = 6'b100000
    } t_bstate;

    t_bstate                   r_state;
    t_cmd                      r_cmd;
    logic [SEG_W-1:0]          r_i;
    logic [ANG_W-1:0]          r_aq;
    logic [SEG_W-1:0]          r_ar;
    logic signed [TRIG_W-1:0]  r_cx, r_cy, r_cz;
    logic                      r_neg;
    logic [KW-1:0]             r_k;
    logic [2:0]                r_mc;
    logic [1:0]                r_tag;
    logic signed [41:0]        r_ph, r_pl;
    t_vert                     r_in_cur, r_out_cur, r_in_prv, r_out_prv;
    logic                      r_ov;

    logic [ANG_W-1:0]          ang, fa;
    logic                      fold;
    logic signed [TRIG_W-1:0]  sx, sy, atn, n_x, n_y, n_z, tr_s, tr_c, trig;
    logic signed [23:0]        mr;
    logic signed [17:0]        mh, ml;
    logic signed [59:0]        acc;
    logic signed [30:0]        sum;
    logic signed [23:0]        org, place;
    logic [SEG_W:0]            nr;
    logic                      last_step, out_free, emit_go;

    assign out_free = !r_ov || o_tri.ready;
    assign emit_go = ((r_state == B_EMIT0) || (r_state == B_EMIT1)) && out_free;
    assign o_tri.valid = r_ov;
    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign last_step = (r_i == r_cmd.n);

    always_comb begin
        ang  = r_cmd.start + r_aq;
        // fold into [-90, 90) degrees by a half turn
        fold = ($signed(ang) >= 16'sd16384) || ($signed(ang) < -16'sd16384);
        fa   = fold ? (ang ^ 16'h8000) : ang;

        atn = TRIG_W'(atan_entry(5'(r_k)));
        sx  = r_cx >>> r_k;
        sy  = r_cy >>> r_k;
        if (r_cz >= 0) begin
            n_x = r_cx - sy;
            n_y = r_cy + sx;
            n_z = r_cz - atn;
        end else begin
            n_x = r_cx + sy;
            n_y = r_cy - sx;
            n_z = r_cz + atn;
        end

        tr_s = r_neg ? -r_cy : r_cy;
        tr_c = r_neg ? -r_cx : r_cx;
        trig = r_mc[0] ? tr_c : tr_s;
        mr   = {1'b0, (r_mc[1] ? r_cmd.r2 : r_cmd.r1)};
        mh   = {trig[TRIG_W-1], trig[TRIG_W-1:17]};
        ml   = {1'b0, trig[16:0]};

        acc   = (60'(r_ph) <<< 17) + 60'(r_pl) + 60'sd536870912;
        org   = r_tag[0] ? r_cmd.oy : r_cmd.ox;
        sum   = 31'($signed(acc[59:30])) + 31'(org);
        if (sum > 31'(COORD_MAX)) begin
            place = COORD_MAX;
        end else if (sum < 31'(COORD_MIN)) begin
            place = COORD_MIN;
        end else begin
            place = sum[23:0];
        end

        nr = {1'b0, r_ar} + {1'b0, r_cmd.r0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (o_tri.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_ANG;
                    end
                end
                B_ANG: r_state <= B_CORD;
                B_CORD: begin
                    if (r_k == KW'(CORDIC_ITERS - 1)) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    if (r_mc == 3'd4) begin
                        if (r_i == '0) begin
                            r_state <= B_ANG;
                        end else begin
                            r_state <= B_EMIT0;
                        end
                    end
                end
                B_EMIT0: begin
                    if (out_free) begin
                        r_state <= B_EMIT1;
                    end
                end
                B_EMIT1: begin
                    if (out_free) begin
                        r_state <= last_step ? B_IDLE : B_ANG;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cmd <= i_cmd;
                r_i   <= '0;
                r_aq  <= '0;
                r_ar  <= '0;
            end
            B_ANG: begin
                r_cx  <= CORDIC_K;
                r_cy  <= '0;
                r_cz  <= {{2{fa[ANG_W-1]}}, fa, 16'b0};
                r_neg <= fold;
                r_k   <= '0;
                r_mc  <= '0;
            end
            B_CORD: begin
                r_cx <= n_x;
                r_cy <= n_y;
                r_cz <= n_z;
                r_k  <= r_k + KW'(1);
            end
            B_MUL: begin
                r_mc <= r_mc + 3'd1;
                if (r_mc != 3'd4) begin
                    r_ph  <= 42'(mr * mh);
                    r_pl  <= 42'(mr * ml);
                    r_tag <= r_mc[1:0];
                end
                if (r_mc != 3'd0) begin
                    case (r_tag)
                        2'd0:    r_in_cur.x  <= place;
                        2'd1:    r_in_cur.y  <= place;
                        2'd2:    r_out_cur.x <= place;
                        default: r_out_cur.y <= place;
                    endcase
                end
                if (r_mc == 3'd4 && r_i == '0) begin
                    // first angle: hold vertices, advance without a triangle
                    r_i <= r_i + SEG_W'(1);
                    if (nr >= {1'b0, r_cmd.n}) begin
                        r_ar <= SEG_W'(nr - {1'b0, r_cmd.n});
                        r_aq <= r_aq + r_cmd.q0 + ANG_W'(1);
                    end else begin
                        r_ar <= nr[SEG_W-1:0];
                        r_aq <= r_aq + r_cmd.q0;
                    end
                end
            end
            B_EMIT1: begin
                if (out_free && !last_step) begin
                    r_i <= r_i + SEG_W'(1);
                    if (nr >= {1'b0, r_cmd.n}) begin
                        r_ar <= SEG_W'(nr - {1'b0, r_cmd.n});
                        r_aq <= r_aq + r_cmd.q0 + ANG_W'(1);
                    end else begin
                        r_ar <= nr[SEG_W-1:0];
                        r_aq <= r_aq + r_cmd.q0;
                    end
                end
            end
            default: ;
        endcase
    end

    // previous column: copy in the angle state after the multiply of the first angle or
    // after the second triangle of each segment but the last
    always_ff @(posedge i_clk) begin
        if ((r_state == B_ANG) && (r_i != '0)) begin
            r_in_prv  <= r_in_cur;
            r_out_prv <= r_out_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_EMIT0 && out_free) begin
            o_tri.ax            <= r_in_prv.x;
            o_tri.ay            <= r_in_prv.y;
            o_tri.bx            <= r_out_prv.x;
            o_tri.by_coord      <= r_out_prv.y;
            o_tri.cx            <= r_out_cur.x;
            o_tri.cy            <= r_out_cur.y;
            o_tri.tri_color     <= r_cmd.color;
            o_tri.last_triangle <= 1'b0;
        end else if (r_state == B_EMIT1 && out_free) begin
            o_tri.ax            <= r_in_prv.x;
            o_tri.ay            <= r_in_prv.y;
            o_tri.bx            <= r_in_cur.x;
            o_tri.by_coord      <= r_in_cur.y;
            o_tri.cx            <= r_out_cur.x;
            o_tri.cy            <= r_out_cur.y;
            o_tri.tri_color     <= r_cmd.color;
            o_tri.last_triangle <= last_step;
        end
    end
endmodule

[rtl/annular_sector_triangulator_top.sv]
`timescale 1ns / 1ps
// Channel    Port        Dir  Word
// sector     i_sector    in   origin, direction, radii, sweep, count, color
// triangle   o_tri       out  three vertices, color, last flag
//
// The time a sector takes is set by the shared sine/cosine CORDIC and the
// multiply sequence of the back end; the front end's vectoring CORDIC and
// divider overlap it.
// A two-entry command queue lets the front take the next sector meanwhile.
// Reset is synchronous, active low. A stalled o_tri holds its word.
module annular_sector_triangulator_top import ast_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ast_sector_if.sink i_sector,
    ast_tri_if.source  o_tri
);
    logic w_push, w_full, w_pop, w_empty;
    t_cmd w_cmd_in, w_cmd_out;

    ast_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .CORDIC_ITERS(CORDIC_ITERS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sector(i_sector),
        .o_push(w_push), .o_cmd(w_cmd_in), .i_full(w_full)
    );

    ast_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cmd(w_cmd_in),
        .o_full(w_full), .i_pop(w_pop), .o_cmd(w_cmd_out), .o_empty(w_empty)
    );

    ast_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_cmd(w_cmd_out),
        .o_pop(w_pop), .o_tri(o_tri)
    );
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import ast_pkg::*;

    typedef struct {
        logic signed [23:0] ax, ay, bx, by_coord, cx, cy;
        logic [31:0]        color;
        logic               last;
    } tri_t;

    // Fixed-point triangulation of one sector, checked against DUT triangles.
    class sector_board;
        tri_t   pending[$];
        int     errors;

        function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        function logic [15:0] start_angle(longint dx, longint dy);
            longint x, y, z, nx, ny;
            logic [31:0] zu;
            if (dx == 0 && dy == 0) return 16'd0;
            x = dy * 1048576;
            y = dx * 1048576;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 64'sd2147483648;
            end
            for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
                if (y > 0) begin
                    nx = x + asr(y, i);
                    ny = y - asr(x, i);
                    z += atan_tab(i);
                end else begin
                    nx = x - asr(y, i);
                    ny = y + asr(x, i);
                    z -= atan_tab(i);
                end
                x = nx;
                y = ny;
            end
            zu = z[31:0] + 32'd32768;
            return zu[31:16];
        endfunction

        function longint atan_tab(int i);
            longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
                163, 81};
            return t[i];
        endfunction

        function void sin_cos(logic [15:0] ang, output longint s, output longint c);
            longint a, x, y, z, nx, ny;
            bit neg;
            a = ang;
            neg = 0;
            x = 652032874;
            y = 0;
            if (a >= 32768) a -= 65536;
            if (a >= 16384) begin
                a -= 32768;
                neg = 1;
            end else if (a < -16384) begin
                a += 32768;
                neg = 1;
            end
            z = a * 65536;
            for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
                if (z >= 0) begin
                    nx = x - asr(y, i);
                    ny = y + asr(x, i);
                    z -= atan_tab(i);
                end else begin
                    nx = x + asr(y, i);
                    ny = y - asr(x, i);
                    z += atan_tab(i);
                end
                x = nx;
                y = ny;
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            s = y;
            c = x;
        endfunction

        function logic signed [23:0] place(longint r, longint trig, longint org);
            longint v;
            v = asr(r * trig + 536870912, 30) + org;
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            return v[23:0];
        endfunction

        function void note_sector(logic signed [23:0] ox, oy, dx, dy, logic [22:0] r1, r2,
                                  logic [15:0] sweep, logic [5:0] cnt, logic [31:0] color);
            logic signed [23:0] ix[33], iy[33], ux[33], uy[33];
            longint n, s, c;
            logic [15:0] st, ang;
            tri_t t;
            n = (cnt > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : cnt;
            if (n == 0) return;
            st = start_angle(dx, dy);
            for (int i = 0; i <= n; i++) begin
                ang = st + 16'((i * longint'(sweep)) / n);
                sin_cos(ang, s, c);
                ix[i] = place(r1, s, ox);
                iy[i] = place(r1, c, oy);
                ux[i] = place(r2, s, ox);
                uy[i] = place(r2, c, oy);
            end
            for (int i = 0; i < n; i++) begin
                t = '{ix[i], iy[i], ux[i], uy[i], ux[i+1], uy[i+1], color, 1'b0};
                pending.push_back(t);
                t = '{ix[i], iy[i], ix[i+1], iy[i+1], ux[i+1], uy[i+1], color, i + 1 == n};
                pending.push_back(t);
            end
        endfunction

        function void check_tri(tri_t got);
            tri_t w;
            if (pending.size() == 0) begin
                report("unexpected triangle");
                return;
            end
            w = pending.pop_front();
            if (got.ax !== w.ax) report("ax");
            if (got.ay !== w.ay) report("ay");
            if (got.bx !== w.bx) report("bx");
            if (got.by_coord !== w.by_coord) report("by_coord");
            if (got.cx !== w.cx) report("cx");
            if (got.cy !== w.cy) report("cy");
            if (got.color !== w.color) report("tri_color");
            if (got.last !== w.last) report("last_triangle");
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 50) $display("mismatch: %s at %0t", what, $time);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ast_sector_if sec_if();
    ast_tri_if    tri_if();
    sector_board  board = new();

    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_off = 0;
    longint cycles = 0;

    annular_sector_triangulator_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sector(sec_if.sink), .o_tri(tri_if.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        sec_if.valid = 0;
        sec_if.origin_x = 0;
        sec_if.origin_y = 0;
        sec_if.dir_x = 0;
        sec_if.dir_y = 0;
        sec_if.inner_radius = 0;
        sec_if.outer_radius = 0;
        sec_if.sweep_angle = 0;
        sec_if.segment_count = 0;
        sec_if.fill_color = 0;
        tri_if.ready = 0;
    end

    // Sink: random stall, optional long hold-off, check each triangle.
    always @(posedge i_clk) begin
        tri_t got;
        cycles <= cycles + 1;
        if (i_rst_n && tri_if.valid && tri_if.ready) begin
            got = '{tri_if.ax, tri_if.ay, tri_if.bx, tri_if.by_coord, tri_if.cx, tri_if.cy,
                    tri_if.tri_color, tri_if.last_triangle};
            board.check_tri(got);
        end
        tri_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (cycles > 4000000) begin
            $display("annular_sector_triangulator_top verification failed");
            $finish;
        end
    end

    // valid stays high from one word to the next unless an idle cycle is taken
    task automatic send_sector(logic signed [23:0] ox, oy, dx, dy, logic [22:0] r1, r2,
                               logic [15:0] sw, logic [5:0] cnt, logic [31:0] col);
        while ($urandom_range(99) < send_idle) begin
            sec_if.valid <= 0;
            @(posedge i_clk);
        end
        sec_if.valid <= 1;
        sec_if.origin_x <= ox;
        sec_if.origin_y <= oy;
        sec_if.dir_x <= dx;
        sec_if.dir_y <= dy;
        sec_if.inner_radius <= r1;
        sec_if.outer_radius <= r2;
        sec_if.sweep_angle <= sw;
        sec_if.segment_count <= cnt;
        sec_if.fill_color <= col;
        @(posedge i_clk);
        while (!sec_if.ready) @(posedge i_clk);
        board.note_sector(ox, oy, dx, dy, r1, r2, sw, cnt, col);
    endtask

    task automatic send_random();
        logic [23:0] ox, oy, dx, dy;
        logic [22:0] r1, r2;
        logic [5:0] cnt;
        ox = 24'($urandom);
        oy = 24'($urandom);
        dx = 24'($urandom);
        dy = 24'($urandom);
        r1 = 23'($urandom);
        r2 = 23'($urandom);
        // mostly small centers and radii, some full range for saturation
        if ($urandom_range(3) != 0) begin
            ox = 24'($signed(ox[15:0]));
            oy = 24'($signed(oy[15:0]));
            r1 = r1 >> $urandom_range(22, 8);
            r2 = r2 >> $urandom_range(22, 8);
        end
        if ($urandom_range(7) == 0) dx = '0;
        if ($urandom_range(7) == 0) dy = '0;
        case ($urandom_range(9))
            0: cnt = 6'($urandom_range(63));
            1: cnt = 6'd0;
            2: cnt = 6'd32;
            default: cnt = 6'($urandom_range(8, 1));
        endcase
        send_sector(ox, oy, dx, dy, r1, r2, 16'($urandom), cnt, 32'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, zero direction, zero/saturated counts
        send_sector(0, 0, 0, 0, 256, 512, 16'h4000, 4, 32'hFFFFFFFF);
        send_sector(0, 0, 0, 0, 0, 0, 0, 0, 32'h0);
        send_sector(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                    23'h7FFFFF, 23'h7FFFFF, 16'hFFFF, 1, 32'hA5A5A5A5);
        send_sector(-24'sh800000, -24'sh800000, -24'sh800000, -24'sh800000,
                    23'h7FFFFF, 0, 16'hFFFF, 2, 32'h5A5A5A5A);
        send_sector(100, -100, -256, 0, 1000, 2000, 16'h8000, 63, 32'h12345678);
        send_sector(0, 0, 256, -256, 1000, 10, 16'h1234, 33, 32'h87654321);
        send_sector(0, 0, 0, -256, 5000, 6000, 16'hC000, 32, 32'h0F0F0F0F);
        send_sector(-5000, 7000, 1, 0, 300, 900, 16'd1, 3, 32'hF0F0F0F0);
        send_sector(0, 0, -1, -1, 23'h400000, 23'h3FFFFF, 16'h7FFF, 5, 32'h1);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 61 : 36) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 61 : 36) : 0;
            for (int k = 0; k < 68; k++) send_random();
        end
        // long receiver hold-off while the source keeps offering sectors
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 6; k++) send_random();
                sec_if.valid <= 0;
            end
        join
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("annular_sector_triangulator_top verification clean");
        else
            $display("annular_sector_triangulator_top verification failed");
        $finish;
    end
endmodule
